[hw/rtl/seeded_region_growing_unit_macros.svh]
// Assertion helpers for the region growing unit.
`ifndef SEEDED_REGION_GROWING_UNIT_MACROS_SVH
`define SEEDED_REGION_GROWING_UNIT_MACROS_SVH

// Same-cycle implication.
`define SRG_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("region growing check failed");

// Next-cycle implication.
`define SRG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("region growing check failed");

`endif

[hw/rtl/srg_pkg.sv]
package srg_pkg;

   localparam int LABEL_BITS = 9;
   localparam int CSR_DATA_BITS = 9;
   localparam int SEED_COORD_BITS = 6;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_SEED  = 2'd1,
      KIND_GROW  = 2'd2,
      KIND_READ  = 2'd3
   } srg_kind_type;

   typedef enum logic [1:0] {
      CSR_WIDTH    = 2'd0,
      CSR_HEIGHT   = 2'd1,
      CSR_CHANNELS = 2'd2,
      CSR_SEEDS    = 2'd3
   } srg_csr_type;

   typedef struct packed {
      srg_kind_type kind;
      logic [11:0]  pixel_index;
      logic [11:0]  chan_a;
      logic [11:0]  chan_b;
      logic [11:0]  chan_c;
      logic [7:0]   seed_number;
      logic [5:0]   seed_col;
      logic [5:0]   seed_row;
   } srg_req_type;

   typedef struct packed {
      logic [8:0] label;
      logic       status;
   } srg_rsp_type;

   typedef enum logic [4:0] {
      ST_CLR_R, ST_IDLE, ST_CLR_A, ST_SEED_RD, ST_SEED_LD, ST_SEED_NEXT, ST_SEED_LRD,
      ST_SEED_LCHK, ST_CLR_B, ST_POP_RD, ST_POP_LD, ST_POP_CH, ST_POP_CMP, ST_PR_LBL,
      ST_PR_CHK, ST_PR_SEED, ST_PR_SPIX, ST_PR_SLD, ST_NB_RD, ST_NB_CHK, ST_NB_COST,
      ST_NB_NEXT, ST_PUSH, ST_PUSH_K, ST_PUSH_CMP, ST_DONE
   } srg_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_IDLE, OP_CLEAR, OP_SEED_RD, OP_SEED_LD, OP_SEED_NEXT, OP_SEED_LRD,
      OP_SEED_LCHK, OP_POP_RD, OP_POP_LD, OP_POP_CH, OP_POP_CMP, OP_PR_LBL, OP_PR_CHK,
      OP_PR_SEED, OP_PR_SPIX, OP_PR_SLD, OP_NB_RD, OP_NB_CHK, OP_NB_COST, OP_NB_NEXT,
      OP_PUSH, OP_PUSH_K, OP_PUSH_CMP, OP_DONE
   } srg_op_type;

   typedef struct packed {
      srg_op_type op;
      logic       accept;
   } srg_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic seed_more;
      logic seed_out;
      logic lbl_nz;
      logic tries_ok;
      logic heap_full;
      logic heap_empty;
      logic push_top;
      logic push_up;
      logic fill_one;
      logic ch_end;
      logic ch_up;
      logic nb_last;
   } srg_stat_type;

endpackage

[hw/rtl/srg_ctrl.sv]
module srg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  srg_pkg::srg_kind_type req_kind,
   input  srg_pkg::srg_stat_type stat,
   output srg_pkg::srg_cmd_type  cmd,
   output logic                  busy
);

   srg_pkg::srg_state_type state_ff, state_in;
   logic ret_seed_ff, ret_seed_in;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= srg_pkg::ST_CLR_R;
         ret_seed_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ret_seed_ff <= ret_seed_in;
      end
   end

   assign busy   = (state_ff != srg_pkg::ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in    = state_ff;
      ret_seed_in = ret_seed_ff;
      cmd.op      = srg_pkg::OP_NONE;
      cmd.accept  = 1'b0;
      unique case (state_ff)
         srg_pkg::ST_CLR_R: begin
            cmd.op = srg_pkg::OP_CLEAR;
            if (stat.clear_last) state_in = srg_pkg::ST_IDLE;
         end
         srg_pkg::ST_IDLE: begin
            cmd.op     = srg_pkg::OP_IDLE;
            cmd.accept = accept;
            if (accept && req_kind == srg_pkg::KIND_GROW) state_in = srg_pkg::ST_CLR_A;
         end
         srg_pkg::ST_CLR_A: begin
            cmd.op = srg_pkg::OP_CLEAR;
            if (stat.clear_last) state_in = srg_pkg::ST_SEED_RD;
         end
         srg_pkg::ST_SEED_RD: begin
            cmd.op   = srg_pkg::OP_SEED_RD;
            state_in = stat.seed_more ? srg_pkg::ST_SEED_LD : srg_pkg::ST_CLR_B;
         end
         srg_pkg::ST_SEED_LD: begin
            cmd.op   = srg_pkg::OP_SEED_LD;
            state_in = stat.seed_out ? srg_pkg::ST_SEED_NEXT : srg_pkg::ST_SEED_LRD;
         end
         srg_pkg::ST_SEED_NEXT: begin
            cmd.op   = srg_pkg::OP_SEED_NEXT;
            state_in = srg_pkg::ST_SEED_RD;
         end
         srg_pkg::ST_SEED_LRD: begin
            cmd.op   = srg_pkg::OP_SEED_LRD;
            state_in = srg_pkg::ST_SEED_LCHK;
         end
         srg_pkg::ST_SEED_LCHK: begin
            cmd.op = srg_pkg::OP_SEED_LCHK;
            if (stat.lbl_nz && stat.tries_ok) begin
               state_in = srg_pkg::ST_SEED_LRD;
            end else begin
               state_in    = srg_pkg::ST_PUSH;
               ret_seed_in = 1'b1;
            end
         end
         srg_pkg::ST_CLR_B: begin
            cmd.op = srg_pkg::OP_CLEAR;
            if (stat.clear_last) state_in = srg_pkg::ST_POP_RD;
         end
         srg_pkg::ST_POP_RD: begin
            cmd.op   = srg_pkg::OP_POP_RD;
            state_in = stat.heap_empty ? srg_pkg::ST_DONE : srg_pkg::ST_POP_LD;
         end
         srg_pkg::ST_POP_LD: begin
            cmd.op   = srg_pkg::OP_POP_LD;
            state_in = stat.fill_one ? srg_pkg::ST_PR_LBL : srg_pkg::ST_POP_CH;
         end
         srg_pkg::ST_POP_CH: begin
            cmd.op   = srg_pkg::OP_POP_CH;
            state_in = stat.ch_end ? srg_pkg::ST_PR_LBL : srg_pkg::ST_POP_CMP;
         end
         srg_pkg::ST_POP_CMP: begin
            cmd.op   = srg_pkg::OP_POP_CMP;
            state_in = stat.ch_up ? srg_pkg::ST_POP_CH : srg_pkg::ST_PR_LBL;
         end
         srg_pkg::ST_PR_LBL: begin
            cmd.op   = srg_pkg::OP_PR_LBL;
            state_in = srg_pkg::ST_PR_CHK;
         end
         srg_pkg::ST_PR_CHK: begin
            cmd.op   = srg_pkg::OP_PR_CHK;
            state_in = stat.lbl_nz ? srg_pkg::ST_POP_RD : srg_pkg::ST_PR_SEED;
         end
         srg_pkg::ST_PR_SEED: begin
            cmd.op   = srg_pkg::OP_PR_SEED;
            state_in = srg_pkg::ST_PR_SPIX;
         end
         srg_pkg::ST_PR_SPIX: begin
            cmd.op   = srg_pkg::OP_PR_SPIX;
            state_in = srg_pkg::ST_PR_SLD;
         end
         srg_pkg::ST_PR_SLD: begin
            cmd.op   = srg_pkg::OP_PR_SLD;
            state_in = srg_pkg::ST_NB_RD;
         end
         srg_pkg::ST_NB_RD: begin
            cmd.op   = srg_pkg::OP_NB_RD;
            state_in = srg_pkg::ST_NB_CHK;
         end
         srg_pkg::ST_NB_CHK: begin
            cmd.op   = srg_pkg::OP_NB_CHK;
            state_in = stat.lbl_nz ? srg_pkg::ST_NB_NEXT : srg_pkg::ST_NB_COST;
         end
         srg_pkg::ST_NB_COST: begin
            cmd.op      = srg_pkg::OP_NB_COST;
            state_in    = srg_pkg::ST_PUSH;
            ret_seed_in = 1'b0;
         end
         srg_pkg::ST_NB_NEXT: begin
            cmd.op   = srg_pkg::OP_NB_NEXT;
            state_in = stat.nb_last ? srg_pkg::ST_POP_RD : srg_pkg::ST_NB_RD;
         end
         srg_pkg::ST_PUSH: begin
            cmd.op = srg_pkg::OP_PUSH;
            if (stat.heap_full)
               state_in = ret_seed_ff ? srg_pkg::ST_SEED_NEXT : srg_pkg::ST_NB_NEXT;
            else
               state_in = srg_pkg::ST_PUSH_K;
         end
         srg_pkg::ST_PUSH_K: begin
            cmd.op = srg_pkg::OP_PUSH_K;
            if (stat.push_top)
               state_in = ret_seed_ff ? srg_pkg::ST_SEED_NEXT : srg_pkg::ST_NB_NEXT;
            else
               state_in = srg_pkg::ST_PUSH_CMP;
         end
         srg_pkg::ST_PUSH_CMP: begin
            cmd.op = srg_pkg::OP_PUSH_CMP;
            if (stat.push_up)
               state_in = srg_pkg::ST_PUSH_K;
            else
               state_in = ret_seed_ff ? srg_pkg::ST_SEED_NEXT : srg_pkg::ST_NB_NEXT;
         end
         srg_pkg::ST_DONE: begin
            cmd.op   = srg_pkg::OP_DONE;
            state_in = srg_pkg::ST_IDLE;
         end
         default: state_in = srg_pkg::ST_IDLE;
      endcase
   end

endmodule

[hw/rtl/srg_dp.sv]
module srg_dp #(
   parameter int MAX_WIDTH   = 64,
   parameter int MAX_HEIGHT  = 64,
   parameter int MAX_SEEDS   = 256,
   parameter int SAMPLE_BITS = 12,
   parameter int HEAP_DEPTH  = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  srg_pkg::srg_cmd_type  cmd,
   input  srg_pkg::srg_req_type  req,
   input  logic                  csr_valid,
   input  srg_pkg::srg_csr_type  csr_index,
   input  logic [8:0]            csr_data,
   output logic                  csr_ready,
   output srg_pkg::srg_stat_type stat,
   output logic                  rsp_strobe,
   output srg_pkg::srg_rsp_type  rsp_payload
);

   localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
   localparam int PA     = $clog2(PIXELS);
   localparam int AW     = (PA > 12) ? PA : 12;
   localparam int SB     = SAMPLE_BITS;
   localparam int XW0    = ($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                           $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT);
   localparam int XW     = (XW0 > srg_pkg::SEED_COORD_BITS) ? XW0 : srg_pkg::SEED_COORD_BITS;
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = $clog2(MAX_HEIGHT + 1);
   localparam int NW     = $clog2(MAX_SEEDS + 1);
   localparam int IW     = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
   localparam int OW     = $clog2(8 * PIXELS + MAX_SEEDS + 1);
   localparam int CW     = ((2 * XW > 2 * SB) ? 2 * XW : 2 * SB) + 3;
   localparam int HA     = $clog2(HEAP_DEPTH);
   localparam int KW     = CW + OW;
   localparam int EW     = KW + 2 * XW + IW;
   localparam int ROW_LSB = IW;
   localparam int COL_LSB = IW + XW;
   localparam int RW     = XW + WW + 1;
   localparam int LBW    = srg_pkg::LABEL_BITS;
   localparam int SCW    = srg_pkg::SEED_COORD_BITS;

   function automatic logic before_f(input logic [EW-1:0] a, input logic [EW-1:0] b);
      before_f = a[EW-1 -: KW] < b[EW-1 -: KW];
   endfunction

   function automatic logic [SB-1:0] absd_s(input logic [SB-1:0] a, input logic [SB-1:0] b);
      absd_s = (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [XW-1:0] absd_x(input logic [XW-1:0] a, input logic [XW-1:0] b);
      absd_x = (a > b) ? a - b : b - a;
   endfunction

   // stores
   logic [3*SB-1:0]  img_mem  [PIXELS];
   logic [LBW-1:0]   lbl_mem  [PIXELS];
   logic [2*SCW-1:0] seed_mem [MAX_SEEDS];
   logic [EW-1:0]    heap_mem [HEAP_DEPTH];
   logic [3*SB-1:0]  img_rd_ff;
   logic [LBW-1:0]   lbl_rd_ff;
   logic [2*SCW-1:0] seed_rd_ff;
   logic [EW-1:0]    ha_rd_ff, hb_rd_ff;

   // control registers
   logic [6:0]    width_ff, height_ff;
   logic [1:0]    chans_ff;
   logic [8:0]    seeds_ff;
   logic [PA-1:0] clr_ff;
   logic [NW-1:0] seed_i_ff;
   logic [HA:0]   fill_ff;
   logic [OW-1:0] seq_ff;
   logic          ovf_ff;
   logic          lbl_pend_ff, lbl_ok_ff, grow_rsp_ff, status_ff;

   // payload registers
   logic [XW-1:0]   cur_col_ff, cur_row_ff, scol_ff, srow_ff, nc_ff, nr_ff;
   logic [WW-1:0]   tries_ff;
   logic [HA-1:0]   k_ff;
   logic [EW-1:0]   e_ff, top_ff, last_ff;
   logic [SB-1:0]   sa_ff, sb_ff, sc_ff;
   logic [2*XW-1:0] sqx_ff, sqy_ff;
   logic [2*SB-1:0] sqa_ff, sqb_ff, sqc_ff;

   logic [WW-1:0]   w_eff;
   logic [HW-1:0]   h_eff;
   logic [NW-1:0]   n_eff;
   logic [AW-1:0]   pix_ext;
   logic            pix_ok;
   logic [XW-1:0]   rc_row, rc_col;
   logic [RW-1:0]   rc_full;
   logic [PA-1:0]   rc_addr;
   logic [XW-1:0]   t_col, t_row, r0, r1, c0, c1;
   logic [IW-1:0]   t_id;
   logic [XW-1:0]   ld_col, ld_row;
   logic [HA-1:0]   parent;
   logic [HA:0]     cc, cc1;
   logic            use_b;
   logic [EW-1:0]   child;
   logic [HA-1:0]   cidx;
   logic [CW-1:0]   cost;
   logic [PA-1:0]   lbl_ra, lbl_wa;
   logic            lbl_we;
   logic [LBW-1:0]  lbl_wd;
   logic [PA-1:0]   img_ra;
   logic [IW-1:0]   seed_ra;
   logic [HA-1:0]   ha_addr, hb_addr, h_wa;
   logic            h_we;
   logic [EW-1:0]   h_wd;
   logic            adv;

   assign csr_ready = 1'b1;

   always_comb begin
      if (width_ff == 7'd0)               w_eff = WW'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else                                w_eff = WW'(width_ff);
      if (height_ff == 7'd0)               h_eff = HW'(1);
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
      else                                 h_eff = HW'(height_ff);
      if (32'(seeds_ff) > MAX_SEEDS) n_eff = NW'(MAX_SEEDS);
      else                           n_eff = NW'(seeds_ff);
   end

   assign pix_ext = AW'(req.pixel_index);
   assign pix_ok  = 32'(pix_ext) < PIXELS;

   assign t_col  = top_ff[COL_LSB +: XW];
   assign t_row  = top_ff[ROW_LSB +: XW];
   assign t_id   = top_ff[IW-1:0];
   assign r0     = (t_row != '0) ? t_row - 1'b1 : t_row;
   assign c0     = (t_col != '0) ? t_col - 1'b1 : t_col;
   assign r1     = (32'(t_row) + 1 < 32'(h_eff)) ? t_row + 1'b1 : t_row;
   assign c1     = (32'(t_col) + 1 < 32'(w_eff)) ? t_col + 1'b1 : t_col;
   assign ld_col = XW'(seed_rd_ff[2*SCW-1 -: SCW]);
   assign ld_row = XW'(seed_rd_ff[SCW-1:0]);

   // shared raster address unit
   always_comb begin
      case (cmd.op) inside
         srg_pkg::OP_PR_LBL, srg_pkg::OP_PR_CHK: begin
            rc_row = t_row;
            rc_col = t_col;
         end
         srg_pkg::OP_PR_SPIX: begin
            rc_row = srow_ff;
            rc_col = scol_ff;
         end
         srg_pkg::OP_NB_RD: begin
            rc_row = nr_ff;
            rc_col = nc_ff;
         end
         default: begin
            rc_row = cur_row_ff;
            rc_col = cur_col_ff;
         end
      endcase
   end
   assign rc_full = RW'(rc_row) * RW'(w_eff) + RW'(rc_col);
   assign rc_addr = rc_full[PA-1:0];

   assign parent = HA'((k_ff - 1'b1) >> 1);
   assign cc     = {k_ff, 1'b1};
   assign cc1    = cc + 1'b1;
   assign use_b  = (cc1 < fill_ff) && before_f(hb_rd_ff, ha_rd_ff);
   assign child  = use_b ? hb_rd_ff : ha_rd_ff;
   assign cidx   = use_b ? cc1[HA-1:0] : cc[HA-1:0];
   assign adv    = stat.lbl_nz && stat.tries_ok;

   assign cost = CW'(sqx_ff) + CW'(sqy_ff)
               + ((chans_ff >= 2'd1) ? CW'(sqa_ff) : CW'(0))
               + ((chans_ff >= 2'd2) ? CW'(sqb_ff) : CW'(0))
               + ((chans_ff == 2'd3) ? CW'(sqc_ff) : CW'(0));

   always_comb begin
      stat.clear_last = (32'(clr_ff) == PIXELS - 1);
      stat.seed_more  = seed_i_ff < n_eff;
      stat.seed_out   = (32'(ld_col) >= 32'(w_eff)) || (32'(ld_row) >= 32'(h_eff));
      stat.lbl_nz     = lbl_rd_ff != '0;
      stat.tries_ok   = tries_ff < w_eff;
      stat.heap_full  = fill_ff >= (HA+1)'(HEAP_DEPTH);
      stat.heap_empty = fill_ff == '0;
      stat.push_top   = k_ff == '0;
      stat.push_up    = before_f(e_ff, ha_rd_ff);
      stat.fill_one   = fill_ff == (HA+1)'(1);
      stat.ch_end     = cc >= fill_ff;
      stat.ch_up      = before_f(child, last_ff);
      stat.nb_last    = (nc_ff == c1) && (nr_ff == r1);
   end

   // memory port steering
   always_comb begin
      lbl_ra  = rc_addr;
      lbl_we  = 1'b0;
      lbl_wa  = rc_addr;
      lbl_wd  = '0;
      img_ra  = rc_addr;
      seed_ra = seed_i_ff[IW-1:0];
      ha_addr = '0;
      hb_addr = '0;
      h_we    = 1'b0;
      h_wa    = k_ff;
      h_wd    = e_ff;
      case (cmd.op)
         srg_pkg::OP_IDLE:  lbl_ra = pix_ext[PA-1:0];
         srg_pkg::OP_CLEAR: begin
            lbl_we = 1'b1;
            lbl_wa = clr_ff;
         end
         srg_pkg::OP_SEED_LCHK: begin
            lbl_we = !adv;
            lbl_wd = LBW'(1);
         end
         srg_pkg::OP_PR_CHK: begin
            lbl_we  = !stat.lbl_nz;
            lbl_wd  = LBW'(t_id) + LBW'(1);
            seed_ra = t_id;
         end
         srg_pkg::OP_PUSH_K: begin
            ha_addr = parent;
            h_we    = stat.push_top;
         end
         srg_pkg::OP_PUSH_CMP: begin
            h_we = 1'b1;
            if (stat.push_up) h_wd = ha_rd_ff;
         end
         srg_pkg::OP_POP_RD: begin
            hb_addr = HA'(fill_ff - 1'b1);
         end
         srg_pkg::OP_POP_CH: begin
            ha_addr = cc[HA-1:0];
            hb_addr = cc1[HA-1:0];
            h_we    = stat.ch_end;
            h_wd    = last_ff;
         end
         srg_pkg::OP_POP_CMP: begin
            h_we = 1'b1;
            h_wd = stat.ch_up ? child : last_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
      lbl_rd_ff <= lbl_mem[lbl_ra];
      if (cmd.accept && req.kind == srg_pkg::KIND_PIXEL && pix_ok)
         img_mem[pix_ext[PA-1:0]] <= {SB'(req.chan_a), SB'(req.chan_b), SB'(req.chan_c)};
      img_rd_ff <= img_mem[img_ra];
      if (cmd.accept && req.kind == srg_pkg::KIND_SEED && 32'(req.seed_number) < MAX_SEEDS)
         seed_mem[IW'(req.seed_number)] <= {req.seed_col, req.seed_row};
      seed_rd_ff <= seed_mem[seed_ra];
      if (h_we) heap_mem[h_wa] <= h_wd;
      ha_rd_ff <= heap_mem[ha_addr];
      hb_rd_ff <= heap_mem[hb_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 7'd64;
         height_ff   <= 7'd64;
         chans_ff    <= 2'd3;
         seeds_ff    <= 9'd0;
         clr_ff      <= '0;
         seed_i_ff   <= '0;
         fill_ff     <= '0;
         seq_ff      <= '0;
         ovf_ff      <= 1'b0;
         lbl_pend_ff <= 1'b0;
         lbl_ok_ff   <= 1'b0;
         grow_rsp_ff <= 1'b0;
         status_ff   <= 1'b0;
      end else begin
         lbl_pend_ff <= 1'b0;
         grow_rsp_ff <= 1'b0;
         if (csr_valid) begin
            unique case (csr_index)
               srg_pkg::CSR_WIDTH:    width_ff  <= csr_data[6:0];
               srg_pkg::CSR_HEIGHT:   height_ff <= csr_data[6:0];
               srg_pkg::CSR_CHANNELS: chans_ff  <= csr_data[1:0];
               srg_pkg::CSR_SEEDS:    seeds_ff  <= csr_data;
               default: ;
            endcase
         end
         case (cmd.op)
            srg_pkg::OP_IDLE: begin
               if (cmd.accept && req.kind == srg_pkg::KIND_GROW) begin
                  seed_i_ff <= '0;
                  fill_ff   <= '0;
                  seq_ff    <= '0;
                  ovf_ff    <= 1'b0;
               end
               if (cmd.accept && req.kind == srg_pkg::KIND_READ) begin
                  lbl_pend_ff <= 1'b1;
                  lbl_ok_ff   <= pix_ok;
               end
            end
            srg_pkg::OP_CLEAR: clr_ff <= stat.clear_last ? '0 : clr_ff + 1'b1;
            srg_pkg::OP_SEED_NEXT: seed_i_ff <= seed_i_ff + 1'b1;
            srg_pkg::OP_PUSH: begin
               if (stat.heap_full) begin
                  ovf_ff <= 1'b1;
               end else begin
                  fill_ff <= fill_ff + 1'b1;
                  seq_ff  <= seq_ff + 1'b1;
               end
            end
            srg_pkg::OP_POP_LD: fill_ff <= fill_ff - 1'b1;
            srg_pkg::OP_DONE: begin
               grow_rsp_ff <= 1'b1;
               status_ff   <= ovf_ff;
            end
            default: ;
         endcase
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      case (cmd.op)
         srg_pkg::OP_SEED_LD: begin
            cur_col_ff <= ld_col;
            cur_row_ff <= ld_row;
            tries_ff   <= '0;
         end
         srg_pkg::OP_SEED_LCHK: begin
            if (adv) begin
               cur_col_ff <= (32'(cur_col_ff) + 1 == 32'(w_eff)) ? '0 : cur_col_ff + 1'b1;
               tries_ff   <= tries_ff + 1'b1;
            end else begin
               e_ff <= {CW'(0), seq_ff, cur_col_ff, cur_row_ff, seed_i_ff[IW-1:0]};
            end
         end
         srg_pkg::OP_PUSH: k_ff <= fill_ff[HA-1:0];
         srg_pkg::OP_PUSH_CMP: if (stat.push_up) k_ff <= parent;
         srg_pkg::OP_POP_LD: begin
            top_ff  <= ha_rd_ff;
            last_ff <= hb_rd_ff;
            k_ff    <= '0;
         end
         srg_pkg::OP_POP_CMP: if (stat.ch_up) k_ff <= cidx;
         srg_pkg::OP_PR_SEED: begin
            scol_ff <= ld_col;
            srow_ff <= ld_row;
         end
         srg_pkg::OP_PR_SLD: begin
            sa_ff <= img_rd_ff[3*SB-1 -: SB];
            sb_ff <= img_rd_ff[2*SB-1 -: SB];
            sc_ff <= img_rd_ff[SB-1:0];
            nr_ff <= r0;
            nc_ff <= c0;
         end
         srg_pkg::OP_NB_CHK: begin
            sqx_ff <= (2*XW)'(absd_x(nc_ff, scol_ff)) * (2*XW)'(absd_x(nc_ff, scol_ff));
            sqy_ff <= (2*XW)'(absd_x(nr_ff, srow_ff)) * (2*XW)'(absd_x(nr_ff, srow_ff));
            sqa_ff <= (2*SB)'(absd_s(img_rd_ff[3*SB-1 -: SB], sa_ff))
                    * (2*SB)'(absd_s(img_rd_ff[3*SB-1 -: SB], sa_ff));
            sqb_ff <= (2*SB)'(absd_s(img_rd_ff[2*SB-1 -: SB], sb_ff))
                    * (2*SB)'(absd_s(img_rd_ff[2*SB-1 -: SB], sb_ff));
            sqc_ff <= (2*SB)'(absd_s(img_rd_ff[SB-1:0], sc_ff))
                    * (2*SB)'(absd_s(img_rd_ff[SB-1:0], sc_ff));
         end
         srg_pkg::OP_NB_COST: e_ff <= {cost, seq_ff, nc_ff, nr_ff, t_id};
         srg_pkg::OP_NB_NEXT: begin
            if (nc_ff == c1) begin
               nc_ff <= c0;
               nr_ff <= nr_ff + 1'b1;
            end else begin
               nc_ff <= nc_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_strobe         = lbl_pend_ff || grow_rsp_ff;
   assign rsp_payload.label  = (lbl_pend_ff && lbl_ok_ff) ? lbl_rd_ff : '0;
   assign rsp_payload.status = grow_rsp_ff && status_ff;

endmodule

[hw/rtl/seeded_region_growing_unit.sv]
// Seeded region growing. Pixel loads, seed loads and label reads are taken one
// per cycle while busy is low and stream back to back; a label read answers on
// rsp_strobe in the cycle after it is taken. A grow holds busy for two label
// clearing sweeps over all MAX_WIDTH*MAX_HEIGHT entries (4096 at the defaults),
// skips each seed that lies outside the image, places the others, then pops the
// heap, labels each popped pixel not yet labeled and pushes its unlabeled
// neighbours; the single heap memory port pair and the registered label memory
// read set its pace. Once the heap runs empty the grow passes through its done
// state and answers on rsp_strobe from a register. After reset the label memory
// is swept to zero over all MAX_WIDTH*MAX_HEIGHT entries with busy high. Results
// are shown for one cycle only; the receiver must take them as they come.
`include "seeded_region_growing_unit_macros.svh"

module seeded_region_growing_unit #(
   parameter int MAX_WIDTH   = 64,
   parameter int MAX_HEIGHT  = 64,
   parameter int MAX_SEEDS   = 256,
   parameter int SAMPLE_BITS = 12,
   parameter int HEAP_DEPTH  = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  srg_pkg::srg_req_type req_payload,
   output logic                 rsp_strobe,
   output srg_pkg::srg_rsp_type rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  srg_pkg::srg_csr_type csr_index,
   input  logic [8:0]           csr_data
);

   srg_pkg::srg_cmd_type  cmd;
   srg_pkg::srg_stat_type stat;

   srg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_payload.kind),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   srg_dp #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .MAX_SEEDS   (MAX_SEEDS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .HEAP_DEPTH  (HEAP_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req         (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .csr_ready   (csr_ready),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   `SRG_ASSERT_NEXT(a_grow_busy, clock, reset, start && !busy && req_payload.kind == srg_pkg::KIND_GROW, busy)
   `SRG_ASSERT_NEXT(a_read_answers, clock, reset, start && !busy && req_payload.kind == srg_pkg::KIND_READ, rsp_strobe)
   `SRG_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy && cmd.op == srg_pkg::OP_IDLE)

endmodule
